// ===== design/pcfk_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcfk_pkg: shared types and constants for the planar chain FK unit
// Field widths, CORDIC constants, the arctangent table and the command
// that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package pcfk_pkg;

	// Field widths
	localparam int JOINT_W       = 16;
	localparam int TRIG_W        = 16;
	localparam int POS_W         = 24;
	localparam int LEN_W         = 16;
	localparam int ANGLE_OUT_W   = 16;

	// Angle resolution: default and widest supported
	localparam int ANGLE_BITS_DEF = 16;
	localparam int ANGLE_MAX_W    = 24;

	// Link length after reset: 2.0 in Q8.8
	localparam logic [LEN_W-1:0] LINK_LEN_RST = 16'd512;

	// CORDIC
	localparam int CORDIC_STEPS = 20;
	localparam int CNT_W        = $clog2(CORDIC_STEPS);
	localparam int CX_W         = 33;
	localparam logic signed [CX_W-1:0] CORDIC_GAIN = 33'sd652032874;

	// Position saturation limits (Q15.8)
	localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
	localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

	// Front-to-back command
	typedef struct packed {
		logic [ANGLE_MAX_W-1:0] angle;
		logic                   root;
		logic                   leaf;
	} pcfk_cmd_t;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ROT,
		BK_RND,
		BK_MUL,
		BK_UPD
	} pcfk_bk_state_t;

	// Arctangent of 2^-i in units of 2^-32 turn
	function automatic logic signed [31:0] atan_turn(input logic [CNT_W-1:0] i);
		logic signed [31:0] r;
		unique case (i)
			5'd0:    r = 32'sd536870912;
			5'd1:    r = 32'sd316933406;
			5'd2:    r = 32'sd167458907;
			5'd3:    r = 32'sd85004756;
			5'd4:    r = 32'sd42667331;
			5'd5:    r = 32'sd21354465;
			5'd6:    r = 32'sd10679838;
			5'd7:    r = 32'sd5340245;
			5'd8:    r = 32'sd2670163;
			5'd9:    r = 32'sd1335087;
			5'd10:   r = 32'sd667544;
			5'd11:   r = 32'sd333772;
			5'd12:   r = 32'sd166886;
			5'd13:   r = 32'sd83443;
			5'd14:   r = 32'sd41722;
			5'd15:   r = 32'sd20861;
			5'd16:   r = 32'sd10430;
			5'd17:   r = 32'sd5215;
			5'd18:   r = 32'sd2608;
			5'd19:   r = 32'sd1304;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/pcfk_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcfk_ifs: channel interfaces of the planar chain FK unit
// Joint-angle input channel and pose result channel, valid/ready.
// ----------------------------------------------------------------------------
interface pcfk_joint_if;
	import pcfk_pkg::*;
	logic               valid;
	logic               ready;
	logic [JOINT_W-1:0] joint_angle;
	logic               last_joint;

	modport source (output valid, output joint_angle, output last_joint, input ready);
	modport sink   (input valid, input joint_angle, input last_joint, output ready);
endinterface

interface pcfk_pose_if;
	import pcfk_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [TRIG_W-1:0]      cos_total;
	logic [TRIG_W-1:0]      sin_total;
	logic [POS_W-1:0]       origin_x;
	logic [POS_W-1:0]       origin_y;
	logic [ANGLE_OUT_W-1:0] angle_total;
	logic                   is_leaf;

	modport source (output valid, output cos_total, output sin_total, output origin_x,
		output origin_y, output angle_total, output is_leaf, input ready);
	modport sink   (input valid, input cos_total, input sin_total, input origin_x,
		input origin_y, input angle_total, input is_leaf, output ready);
endinterface
`default_nettype wire

// ===== design/pcfk_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcfk_front: joint intake
// Accepts joint transactions, accumulates the chain angle, tags root and
// leaf joints and pushes a command toward the back end.
// ----------------------------------------------------------------------------
module pcfk_front #(
	parameter int ANGLE_BITS = pcfk_pkg::ANGLE_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	pcfk_joint_if.sink             joint,
	output logic                   push_valid,
	input  wire logic              push_ready,
	output pcfk_pkg::pcfk_cmd_t    push_cmd
);
	import pcfk_pkg::*;

	localparam int InW = (ANGLE_BITS < JOINT_W) ? ANGLE_BITS : JOINT_W;

	logic                  at_root_q;
	logic [ANGLE_BITS-1:0] run_angle_q;
	logic [ANGLE_BITS-1:0] ang_in;
	logic [ANGLE_BITS-1:0] total;
	logic                  accept;

	// Cumulative angle, wraps at one full turn
	always_comb begin
		ang_in = ANGLE_BITS'(joint.joint_angle[InW-1:0]);
		total  = at_root_q ? ang_in : run_angle_q + ang_in;
	end

	assign accept       = joint.valid && push_ready;
	assign joint.ready  = push_ready;
	assign push_valid   = joint.valid;
	assign push_cmd.angle = ANGLE_MAX_W'(total);
	assign push_cmd.root  = at_root_q;
	assign push_cmd.leaf  = joint.last_joint;

	// Chain state: a leaf restarts the chain at the root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_root_q   <= 1'b1;
			run_angle_q <= '0;
		end else if (accept) begin
			at_root_q   <= joint.last_joint;
			run_angle_q <= joint.last_joint ? '0 : total;
		end
	end

endmodule
`default_nettype wire

// ===== design/pcfk_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcfk_queue: command queue
// Two-entry FIFO that decouples joint intake from the CORDIC back end.
// ----------------------------------------------------------------------------
module pcfk_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	output logic                   push_ready,
	input  wire pcfk_pkg::pcfk_cmd_t push_cmd,
	output logic                   pop_valid,
	input  wire logic              pop_ready,
	output pcfk_pkg::pcfk_cmd_t    pop_cmd
);
	import pcfk_pkg::*;

	pcfk_cmd_t  ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_cmd    = ent_q[rp_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= ~wp_q;
			end
			if (do_pop) begin
				rp_q <= ~rp_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/pcfk_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcfk_back: trig and position engine
// Iterative CORDIC (one micro-rotation per cycle) for cos/sin of the
// cumulative angle, then link-length scaling and saturating position update.
// Holds the result in an output register until the sink takes it.
// ----------------------------------------------------------------------------
module pcfk_back #(
	parameter int ANGLE_BITS = pcfk_pkg::ANGLE_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cmd_valid,
	output logic                           cmd_ready,
	input  wire pcfk_pkg::pcfk_cmd_t       cmd,
	input  wire logic [pcfk_pkg::LEN_W-1:0] link_len,
	pcfk_pose_if.source                    pose
);
	import pcfk_pkg::*;

	localparam int PShift = 32 - ANGLE_BITS;

	pcfk_bk_state_t state_q;
	pcfk_bk_state_t state_nxt;

	// Sequencer strobes
	logic load;
	logic step;
	logic rnd;
	logic mul;
	logic wr;
	logic last_step;

	// Working registers
	logic [CNT_W-1:0]         cnt_q;
	logic signed [CX_W-1:0]   x_q;
	logic signed [CX_W-1:0]   y_q;
	logic signed [31:0]       z_q;
	logic [ANGLE_MAX_W-1:0]   total_q;
	logic                     leaf_q;
	logic signed [POS_W-1:0]  org_x_q;
	logic signed [POS_W-1:0]  org_y_q;
	logic signed [POS_W-1:0]  run_x_q;
	logic signed [POS_W-1:0]  run_y_q;
	logic signed [TRIG_W-1:0] cos_q;
	logic signed [TRIG_W-1:0] sin_q;
	logic signed [32:0]       prod_x_q;
	logic signed [32:0]       prod_y_q;

	// Output register
	logic                     ovalid_q;
	logic [TRIG_W-1:0]        ocos_q;
	logic [TRIG_W-1:0]        osin_q;
	logic [POS_W-1:0]         ox_q;
	logic [POS_W-1:0]         oy_q;
	logic [ANGLE_OUT_W-1:0]   oang_q;
	logic                     oleaf_q;

	// Datapath nets
	logic [31:0]              p;
	logic signed [CX_W-1:0]   x0;
	logic signed [CX_W-1:0]   y0;
	logic signed [CX_W-1:0]   dx;
	logic signed [CX_W-1:0]   dy;
	logic signed [31:0]       atn;
	logic signed [CX_W:0]     vx;
	logic signed [CX_W:0]     vy;
	logic signed [TRIG_W-1:0] c_sat;
	logic signed [TRIG_W-1:0] s_sat;
	logic signed [16:0]       len_s;
	logic signed [33:0]       rx;
	logic signed [33:0]       ry;
	logic signed [34:0]       nx;
	logic signed [34:0]       ny;

	function automatic logic signed [TRIG_W-1:0] sat_trig(input logic signed [CX_W:0] v);
		logic signed [CX_W:0] sh;
		logic signed [TRIG_W-1:0] r;
		sh = v >>> 15;
		if (sh > 34'sd32767) begin
			r = 16'sh7FFF;
		end else if (sh < -34'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = TRIG_W'(sh);
		end
		return r;
	endfunction

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [34:0] v);
		logic signed [POS_W-1:0] r;
		if (v > 35'(POS_MAX)) begin
			r = POS_MAX;
		end else if (v < 35'(POS_MIN)) begin
			r = POS_MIN;
		end else begin
			r = POS_W'(v);
		end
		return r;
	endfunction

	// Next state
	assign last_step = (cnt_q == CNT_W'(CORDIC_STEPS - 1));

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			BK_IDLE: if (cmd_valid) state_nxt = BK_ROT;
			BK_ROT:  if (last_step) state_nxt = BK_RND;
			BK_RND:  state_nxt = BK_MUL;
			BK_MUL:  state_nxt = BK_UPD;
			BK_UPD:  if (!ovalid_q || pose.ready) state_nxt = BK_IDLE;
			default: state_nxt = BK_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		load = 1'b0;
		step = 1'b0;
		rnd  = 1'b0;
		mul  = 1'b0;
		wr   = 1'b0;
		unique case (state_q)
			BK_IDLE: load = cmd_valid;
			BK_ROT:  step = 1'b1;
			BK_RND:  rnd  = 1'b1;
			BK_MUL:  mul  = 1'b1;
			BK_UPD:  wr   = !ovalid_q || pose.ready;
			default: load = 1'b0;
		endcase
	end

	assign cmd_ready = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Start vector from the quadrant bits
	always_comb begin
		p  = 32'(cmd.angle) << PShift;
		x0 = '0;
		y0 = '0;
		case (p[31:30])
			2'd0:    x0 = CORDIC_GAIN;
			2'd1:    y0 = CORDIC_GAIN;
			2'd2:    x0 = -CORDIC_GAIN;
			default: y0 = -CORDIC_GAIN;
		endcase
	end

	// One micro-rotation
	assign dx  = y_q >>> cnt_q;
	assign dy  = x_q >>> cnt_q;
	assign atn = atan_turn(cnt_q);

	// Rounding to Q1.15 and scaling by link length
	assign vx    = (CX_W+1)'(x_q) + 34'sd16384;
	assign vy    = (CX_W+1)'(y_q) + 34'sd16384;
	assign c_sat = sat_trig(vx);
	assign s_sat = sat_trig(vy);
	assign len_s = signed'({1'b0, link_len});

	// Child position: origin plus rounded link step
	assign rx = (34'(prod_x_q) + 34'sd16384) >>> 15;
	assign ry = (34'(prod_y_q) + 34'sd16384) >>> 15;
	assign nx = 35'(org_x_q) + 35'(rx);
	assign ny = 35'(org_y_q) + 35'(ry);

	// CORDIC and product datapath
	always_ff @(posedge clk) begin
		if (load) begin
			x_q     <= x0;
			y_q     <= y0;
			z_q     <= signed'({2'b00, p[29:0]});
			cnt_q   <= '0;
			total_q <= cmd.angle;
			leaf_q  <= cmd.leaf;
			org_x_q <= cmd.root ? '0 : run_x_q;
			org_y_q <= cmd.root ? '0 : run_y_q;
		end
		if (step) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (!z_q[31]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atn;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atn;
			end
		end
		if (rnd) begin
			cos_q <= c_sat;
			sin_q <= s_sat;
		end
		if (mul) begin
			prod_x_q <= len_s * cos_q;
			prod_y_q <= len_s * sin_q;
		end
	end

	// Running position of the next joint
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_x_q <= '0;
			run_y_q <= '0;
		end else if (wr) begin
			run_x_q <= leaf_q ? '0 : sat_pos(nx);
			run_y_q <= leaf_q ? '0 : sat_pos(ny);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (wr) begin
			ovalid_q <= 1'b1;
		end else if (pose.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			ocos_q  <= cos_q;
			osin_q  <= sin_q;
			ox_q    <= org_x_q;
			oy_q    <= org_y_q;
			oang_q  <= total_q[ANGLE_OUT_W-1:0];
			oleaf_q <= leaf_q;
		end
	end

	assign pose.valid       = ovalid_q;
	assign pose.cos_total   = ocos_q;
	assign pose.sin_total   = osin_q;
	assign pose.origin_x    = ox_q;
	assign pose.origin_y    = oy_q;
	assign pose.angle_total = oang_q;
	assign pose.is_leaf     = oleaf_q;

endmodule
`default_nettype wire

// ===== design/planar_chain_forward_kinematics_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// planar_chain_forward_kinematics_unit: planar serial chain FK
// Joint angles in, root to leaf; per joint the cos/sin of the cumulative
// angle (Q1.15), the joint's world origin (Q15.8, saturating) and the
// cumulative angle out.
// ----------------------------------------------------------------------------
// Joint transactions enter a two-entry queue, so up to two joints are taken
// ahead of the engine. Per joint the engine loads the command, runs the
// iterative CORDIC (one micro-rotation per cycle), rounds, does the
// link-length multiply and writes the result register. It takes a new
// joint only after that write; a stalled result holds it in the write
// state. The link length (unsigned Q8.8, 2.0 after reset) is written
// through cfg_wr_en / cfg_wr_data and must only change while the unit is
// idle. A joint flagged last_joint ends the chain; the next joint is a
// root at the origin.
// ----------------------------------------------------------------------------
module planar_chain_forward_kinematics_unit #(
	parameter int ANGLE_BITS = pcfk_pkg::ANGLE_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	pcfk_joint_if.sink                      joint,
	pcfk_pose_if.source                     pose,
	input  wire logic                       cfg_wr_en,
	input  wire logic [pcfk_pkg::LEN_W-1:0] cfg_wr_data
);
	import pcfk_pkg::*;

	logic [LEN_W-1:0] len_q;
	logic             push_valid;
	logic             push_ready;
	pcfk_cmd_t        push_cmd;
	logic             pop_valid;
	logic             pop_ready;
	pcfk_cmd_t        pop_cmd;

	// Link length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LINK_LEN_RST;
		end else if (cfg_wr_en) begin
			len_q <= cfg_wr_data;
		end
	end

	pcfk_front #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.joint     (joint),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd)
	);

	pcfk_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd)
	);

	pcfk_back #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(pop_valid),
		.cmd_ready(pop_ready),
		.cmd      (pop_cmd),
		.link_len (len_q),
		.pose     (pose)
	);

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: planar chain forward kinematics unit
// Sends chains of joint angles and predicts each pose from a CORDIC model
// of its own. Covers quadrant and wrap angles, chain restart after a leaf,
// and link length extremes, including a change in the middle of a chain.
// Long chains drive the origin into saturation. Random chains run under
// three idle and stall mixes. Each pose is checked field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
	import pcfk_pkg::*;

	localparam int     CLK_HALF      = 4;
	localparam int     RESET_CYCLES  = 8;
	localparam int     QUIET_LIMIT   = 5000;
	localparam int     SETTLE_CYCLES = 64;
	localparam int     IDLE_GUARD    = 4;
	localparam int     SAT_CHAIN     = 190;
	localparam int     ROTATIONS     = 20;
	localparam longint UNIT_GAIN     = 652032874;
	localparam longint ORIGIN_MAX    = 8388607;
	localparam longint ORIGIN_MIN    = -8388608;

	typedef struct {
		logic [TRIG_W-1:0]      cos_total;
		logic [TRIG_W-1:0]      sin_total;
		logic [POS_W-1:0]       origin_x;
		logic [POS_W-1:0]       origin_y;
		logic [ANGLE_OUT_W-1:0] angle_total;
		logic                   is_leaf;
	} pose_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [LEN_W-1:0] cfg_wr_data;

	pcfk_joint_if joint_ch ();
	pcfk_pose_if  pose_ch ();

	planar_chain_forward_kinematics_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.joint       (joint_ch),
		.pose        (pose_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// Chain state of the predictor
	logic [LEN_W-1:0]   link_len_q88  = 16'd512;
	logic [JOINT_W-1:0] chain_angle   = '0;
	longint             chain_x       = 0;
	longint             chain_y       = 0;
	logic               chain_at_root = 1'b1;

	pose_t pending_poses[$];
	int    mismatch_count = 0;
	int    joint_gap_pct  = 7;
	int    pose_stall_pct = 78;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Pose predictor
	// ------------------------------------------------------------------------
	function automatic longint saturate(input longint v, input longint lo, input longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// arctan(2^-i) in 2^-32 turn
	function automatic longint arctan_turn32(input int step);
		case (step)
			0:       return 536870912;
			1:       return 316933406;
			2:       return 167458907;
			3:       return 85004756;
			4:       return 42667331;
			5:       return 21354465;
			6:       return 10679838;
			7:       return 5340245;
			8:       return 2670163;
			9:       return 1335087;
			10:      return 667544;
			11:      return 333772;
			12:      return 166886;
			13:      return 83443;
			14:      return 41722;
			15:      return 20861;
			16:      return 10430;
			17:      return 5215;
			18:      return 2608;
			19:      return 1304;
			default: return 0;
		endcase
	endfunction

	// Quadrant start vector, then CORDIC rotations; angle resolution is 16 bits
	function automatic void unit_vector(input logic [JOINT_W-1:0] angle,
		output logic [TRIG_W-1:0] cos_q, output logic [TRIG_W-1:0] sin_q);
		logic [31:0] turn;
		longint      x;
		longint      y;
		longint      z;
		longint      dx;
		longint      dy;
		int          i;
		turn = {angle, 16'h0000};
		z = longint'(turn[29:0]);
		x = 0;
		y = 0;
		case (turn[31:30])
			2'd0: begin
				x = UNIT_GAIN;
			end
			2'd1: begin
				y = UNIT_GAIN;
			end
			2'd2: begin
				x = -UNIT_GAIN;
			end
			default: begin
				y = -UNIT_GAIN;
			end
		endcase
		for (i = 0; i < ROTATIONS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - arctan_turn32(i);
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + arctan_turn32(i);
			end
		end
		cos_q = 16'(saturate((x + 16384) >>> 15, -32768, 32767));
		sin_q = 16'(saturate((y + 16384) >>> 15, -32768, 32767));
	endfunction

	// One joint in: queue its pose, step the chain to the child joint
	function automatic void predict_pose(input logic [JOINT_W-1:0] angle, input logic leaf);
		pose_t              p;
		logic [JOINT_W-1:0] total;
		longint             ox;
		longint             oy;
		logic [TRIG_W-1:0]  c;
		logic [TRIG_W-1:0]  s;
		if (chain_at_root) begin
			total = angle;
			ox = 0;
			oy = 0;
		end else begin
			total = chain_angle + angle;
			ox = chain_x;
			oy = chain_y;
		end
		unit_vector(total, c, s);
		p.cos_total   = c;
		p.sin_total   = s;
		p.origin_x    = ox[POS_W-1:0];
		p.origin_y    = oy[POS_W-1:0];
		p.angle_total = total;
		p.is_leaf     = leaf;
		pending_poses.push_back(p);

		if (leaf) begin
			chain_angle   = '0;
			chain_x       = 0;
			chain_y       = 0;
			chain_at_root = 1'b1;
		end else begin
			chain_angle   = total;
			chain_x = saturate(ox + ((longint'(link_len_q88) * longint'($signed(c)) + 16384) >>> 15),
				ORIGIN_MIN, ORIGIN_MAX);
			chain_y = saturate(oy + ((longint'(link_len_q88) * longint'($signed(s)) + 16384) >>> 15),
				ORIGIN_MIN, ORIGIN_MAX);
			chain_at_root = 1'b0;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Joint side
	// ------------------------------------------------------------------------
	task automatic send_joint(input logic [JOINT_W-1:0] angle, input logic leaf);
		while ($urandom_range(1, 100) <= joint_gap_pct) begin
			joint_ch.valid <= 1'b0;
			@(posedge clk);
		end
		joint_ch.valid       <= 1'b1;
		joint_ch.joint_angle <= angle;
		joint_ch.last_joint  <= leaf;
		@(posedge clk);
		while (!joint_ch.ready)
			@(posedge clk);
		predict_pose(angle, leaf);
	endtask

	// Hold off joints until every queued pose has come out
	task automatic drain_pipeline();
		joint_ch.valid <= 1'b0;
		while (pending_poses.size() != 0)
			@(posedge clk);
		repeat (IDLE_GUARD) @(posedge clk);
	endtask

	// Link length is only written with the unit idle
	task automatic reconfigure(input logic [LEN_W-1:0] value);
		drain_pipeline();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en    <= 1'b0;
		link_len_q88  = value;
	endtask

	function automatic logic [JOINT_W-1:0] pick_angle();
		case ($urandom_range(0, 11))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'h4000;
			3:       return 16'h8000;
			4:       return 16'hC000;
			5:       return {2'($urandom), 14'h3FFF};
			6:       return 16'($urandom_range(0, 31));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [LEN_W-1:0] pick_link_length();
		case ($urandom_range(0, 5))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'h0001;
			3:       return 16'h0200;
			default: return 16'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Pose side: random stall, check each transaction against the queue
	// ------------------------------------------------------------------------
	function automatic void compare_field(input string field, input logic [POS_W-1:0] want,
		input logic [POS_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			mismatch_count++;
		end
	endfunction

	task automatic check_pose();
		pose_t want;
		if (pending_poses.size() == 0) begin
			$error("pose transaction with nothing expected: angle_total 0x%0h",
				pose_ch.angle_total);
			mismatch_count++;
		end else begin
			want = pending_poses.pop_front();
			compare_field("cos_total", want.cos_total, pose_ch.cos_total);
			compare_field("sin_total", want.sin_total, pose_ch.sin_total);
			compare_field("origin_x", want.origin_x, pose_ch.origin_x);
			compare_field("origin_y", want.origin_y, pose_ch.origin_y);
			compare_field("angle_total", want.angle_total, pose_ch.angle_total);
			compare_field("is_leaf", want.is_leaf, pose_ch.is_leaf);
		end
	endtask

	initial begin
		pose_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pose_ch.valid && pose_ch.ready)
				check_pose();
			pose_ch.ready <= ($urandom_range(1, 100) > pose_stall_pct);
		end
	end

	// Watchdog: too long without any transaction ends the run
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((joint_ch.valid && joint_ch.ready) || (pose_ch.valid && pose_ch.ready) || cfg_wr_en)
				quiet = 0;
			else
				quiet++;
		end
		$display("testbench: done, errors");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	// Single-joint chains: quadrant starts, boundaries and extremes
	task automatic test_root_angles();
		send_joint(16'h0000, 1'b1);
		send_joint(16'h4000, 1'b1);
		send_joint(16'h8000, 1'b1);
		send_joint(16'hC000, 1'b1);
		send_joint(16'hFFFF, 1'b1);
		send_joint(16'h0001, 1'b1);
		send_joint(16'h3FFF, 1'b1);
		send_joint(16'h2000, 1'b1);
		send_joint(16'h5555, 1'b1);
		send_joint(16'hAAAA, 1'b1);
	endtask

	// Angle sums wrap; a new chain restarts at the origin; reset link length
	task automatic test_chain_accumulation();
		send_joint(16'h4000, 1'b0);
		send_joint(16'h4000, 1'b0);
		send_joint(16'h4000, 1'b0);
		send_joint(16'h4000, 1'b0);
		send_joint(16'hFFFF, 1'b0);
		send_joint(16'h0001, 1'b0);
		send_joint(16'h8000, 1'b1);
		send_joint(16'h1000, 1'b0);
		send_joint(16'h1000, 1'b1);
	endtask

	// Zero and full link, then a change between a parent and its child
	task automatic test_link_length();
		reconfigure(16'h0000);
		send_joint(16'h1000, 1'b0);
		send_joint(16'h2000, 1'b0);
		send_joint(16'h3000, 1'b1);
		reconfigure(16'hFFFF);
		send_joint(16'h0000, 1'b0);
		send_joint(16'h8000, 1'b0);
		send_joint(16'h4000, 1'b1);
		reconfigure(16'h0100);
		send_joint(16'h2000, 1'b0);
		send_joint(16'h1000, 1'b0);
		reconfigure(16'h0380);
		send_joint(16'h0800, 1'b0);
		send_joint(16'hF000, 1'b1);
	endtask

	// Long chains at full link length run both origins into each limit
	task automatic test_position_saturation();
		int                 h;
		int                 k;
		logic [JOINT_W-1:0] heading;
		reconfigure(16'hFFFF);
		for (h = 0; h < 2; h++) begin
			heading = (h == 0) ? 16'h2000 : 16'hA000;
			send_joint(heading, 1'b0);
			for (k = 1; k < SAT_CHAIN; k++)
				send_joint(16'($urandom_range(0, 32)) - 16'd16, k == SAT_CHAIN - 1);
		end
	endtask

	// Random chains; link length rewritten now and then, often mid-chain
	task automatic test_random_chains(input int item_count, input int gap_pct,
		input int stall_pct);
		int sent;
		int chain_len;
		int k;
		int next_write;
		joint_gap_pct  = gap_pct;
		pose_stall_pct = stall_pct;
		sent       = 0;
		next_write = $urandom_range(30, 70);
		while (sent < item_count) begin
			chain_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
			for (k = 0; k < chain_len; k++) begin
				send_joint(pick_angle(), k == chain_len - 1);
				sent++;
				if (sent >= next_write) begin
					reconfigure(pick_link_length());
					next_write = sent + $urandom_range(30, 70);
				end
			end
		end
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_wr_en            = 1'b0;
		cfg_wr_data          = '0;
		joint_ch.valid       = 1'b0;
		joint_ch.joint_angle = '0;
		joint_ch.last_joint  = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_root_angles();
		test_chain_accumulation();
		test_link_length();
		test_position_saturation();
		test_random_chains(20, 7, 78);
		test_random_chains(20, 78, 7);
		test_random_chains(20, 0, 0);

		drain_pipeline();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_poses.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
